### rtl/projective_inverse_warp_coords_top_defines.svh
// Assertion helpers for the warp-coordinate top level.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef PROJECTIVE_INVERSE_WARP_COORDS_TOP_DEFINES_SVH
`define PROJECTIVE_INVERSE_WARP_COORDS_TOP_DEFINES_SVH

// Implication check: whenever ante holds, cons holds in the same cycle.
`define PIW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define PIW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/piw_pkg.sv
`default_nettype none

package piw_pkg;

  // Coordinate and register geometry
  localparam int unsigned CoordW       = 10;
  localparam int unsigned CoordBitsDef = 10;
  localparam int unsigned SrcWidthDef  = 510;
  localparam int unsigned SrcHeightDef = 370;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegNumXFromX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNumXFromY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNumXOffs  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNumYFromX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNumYFromY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNumYOffs  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDenFromX  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDenFromY  = 3'd7;

  // Fixed point: weights are Q4.28, offsets Q16.16 scaled up by 2^12
  localparam int unsigned FracBits    = 28;
  localparam int unsigned OffsetShift = 12;
  localparam logic [CoefW-1:0] FracOne = CoefW'(64'd1 << FracBits);

  // Datapath widths
  localparam int unsigned ProdW = CoefW + CoordW + 1;      // signed weight * coord
  localparam int unsigned NumW  = 46;                      // signed sums, |v| < 2^44
  localparam int unsigned QW    = 12;                      // quotient bits, MSB = overflow
  localparam int unsigned RemW  = NumW - 1 + QW;           // partial remainder / shifted den

  // Queue depths (credit limits)
  localparam int unsigned MidDepth = 4;
  localparam int unsigned OutDepth = 16;

  typedef struct packed {
    logic              ok;    // den > 0, nx > 0, ny > 0
    logic [NumW-2:0]   nx;
    logic [NumW-2:0]   ny;
    logic [NumW-2:0]   den;
  } piw_item_t;

  typedef struct packed {
    logic              in_range;
    logic [CoordW-1:0] src_x;
    logic [CoordW-1:0] src_y;
  } piw_res_t;

  function automatic logic [CoefW-1:0] cfg_reset(input logic [CfgIdxW-1:0] idx);
    return ((idx == RegNumXFromX) || (idx == RegNumYFromY)) ? FracOne : '0;
  endfunction

endpackage

`default_nettype wire

### rtl/piw_fifo.sv
`default_nettype none

module piw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;

  assign rdata_o = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/piw_front.sv
`default_nettype none

module piw_front import piw_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoefW-1:0]   cfg_wdata_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [CoordW-1:0]  out_x_i,
  input  wire logic [CoordW-1:0]  out_y_i,
  input  wire logic               mid_pop_i,
  output logic                    mid_push_o,
  output piw_item_t               mid_item_o
);

  localparam int unsigned MaskBits = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam logic [CoordW-1:0] CoordMask = CoordW'((64'd1 << MaskBits) - 64'd1);
  localparam int unsigned CntW = $clog2(MidDepth + 1);

  logic signed [CoefW-1:0] coef_q [NumRegs];

  logic                    accept;
  logic signed [CoordW:0]  xs, ys;
  logic signed [ProdW-1:0] prod [6];
  logic signed [ProdW-1:0] prod_q [6];
  logic                    v1_q, v2_q;
  logic signed [NumW-1:0]  nx_d, ny_d, den_d;
  logic signed [NumW-1:0]  nx_q, ny_q, den_q;
  logic [CntW-1:0]         cnt_q;

  // Items in the two stages plus the queue never exceed the queue depth
  assign full   = (cnt_q == CntW'(MidDepth));
  assign accept = push && !full;

  assign xs = $signed({1'b0, out_x_i & CoordMask});
  assign ys = $signed({1'b0, out_y_i & CoordMask});

  always_comb begin
    prod[0] = coef_q[RegNumXFromX] * xs;
    prod[1] = coef_q[RegNumXFromY] * ys;
    prod[2] = coef_q[RegNumYFromX] * xs;
    prod[3] = coef_q[RegNumYFromY] * ys;
    prod[4] = coef_q[RegDenFromX]  * xs;
    prod[5] = coef_q[RegDenFromY]  * ys;
  end

  always_comb begin
    nx_d  = NumW'(prod_q[0]) + NumW'(prod_q[1])
          + NumW'($signed({coef_q[RegNumXOffs], OffsetShift'(0)}));
    ny_d  = NumW'(prod_q[2]) + NumW'(prod_q[3])
          + NumW'($signed({coef_q[RegNumYOffs], OffsetShift'(0)}));
    den_d = NumW'(prod_q[4]) + NumW'(prod_q[5]) + NumW'($signed({1'b0, FracOne}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumRegs; k++) begin
        coef_q[k] <= cfg_reset(CfgIdxW'(k));
      end
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        coef_q[cfg_idx_i] <= cfg_wdata_i;
      end
      v1_q  <= accept;
      v2_q  <= v1_q;
      cnt_q <= cnt_q + CntW'(accept) - CntW'(mid_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    den_q  <= den_d;
  end

  assign mid_push_o     = v2_q;
  assign mid_item_o.ok  = !den_q[NumW-1] && (den_q != '0)
                       && !nx_q[NumW-1]  && (nx_q != '0)
                       && !ny_q[NumW-1]  && (ny_q != '0);
  assign mid_item_o.nx  = nx_q[NumW-2:0];
  assign mid_item_o.ny  = ny_q[NumW-2:0];
  assign mid_item_o.den = den_q[NumW-2:0];

endmodule

`default_nettype wire

### rtl/piw_back.sv
`default_nettype none

module piw_back import piw_pkg::*; #(
  parameter int unsigned SRC_WIDTH  = SrcWidthDef,
  parameter int unsigned SRC_HEIGHT = SrcHeightDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              mid_empty_i,
  input  wire piw_item_t         mid_item_i,
  output logic                   mid_pop_o,
  input  wire logic              pop,
  output logic                   empty,
  output logic                   in_range_o,
  output logic [CoordW-1:0]      src_x_o,
  output logic [CoordW-1:0]      src_y_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  typedef struct packed {
    logic            ok;
    logic [NumW-2:0] d;
    logic [RemW-1:0] rx;
    logic [RemW-1:0] ry;
    logic [QW-1:0]   qx;
    logic [QW-1:0]   qy;
  } stage_t;

  stage_t          st_q [QW+1];
  stage_t          st_d [QW];
  logic [QW:0]     vld_q;
  logic [CntW-1:0] cnt_q;
  piw_res_t        res;
  piw_res_t        head;
  logic            out_pop;

  // Credit: items past the queue head until their result is popped
  assign mid_pop_o = !mid_empty_i && (cnt_q != CntW'(OutDepth));
  assign out_pop   = pop && !empty;

  // Restoring division, one quotient bit per stage, MSB first.
  // The top bit only flags a quotient of 2048 or more.
  always_comb begin
    logic [RemW-1:0] dk;
    int unsigned     k;
    for (int j = 0; j < QW; j++) begin
      k        = QW - 1 - j;
      dk       = RemW'(st_q[j].d) << k;
      st_d[j]  = st_q[j];
      if (st_q[j].rx >= dk) begin
        st_d[j].rx    = st_q[j].rx - dk;
        st_d[j].qx[k] = 1'b1;
      end
      if (st_q[j].ry >= dk) begin
        st_d[j].ry    = st_q[j].ry - dk;
        st_d[j].qy[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], mid_pop_o};
      cnt_q <= cnt_q + CntW'(mid_pop_o) - CntW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      st_q[0].ok <= mid_item_i.ok;
      st_q[0].d  <= mid_item_i.den;
      st_q[0].rx <= RemW'(mid_item_i.nx);
      st_q[0].ry <= RemW'(mid_item_i.ny);
      st_q[0].qx <= '0;
      st_q[0].qy <= '0;
    end
    for (int j = 0; j < QW; j++) begin
      st_q[j+1] <= st_d[j];
    end
  end

  // Strict bounds: integer quotient below the size is the same test as X < size
  always_comb begin
    res.in_range = st_q[QW].ok
                && (st_q[QW].qx < QW'(SRC_WIDTH))
                && (st_q[QW].qy < QW'(SRC_HEIGHT));
    res.src_x    = res.in_range ? st_q[QW].qx[CoordW-1:0] : '0;
    res.src_y    = res.in_range ? st_q[QW].qy[CoordW-1:0] : '0;
  end

  piw_fifo #(
    .WIDTH ($bits(piw_res_t)),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (vld_q[QW]),
    .wdata_i (res),
    .pop_i   (out_pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  ()
  );

  assign in_range_o = head.in_range;
  assign src_x_o    = head.src_x;
  assign src_y_o    = head.src_y;

endmodule

`default_nettype wire

### rtl/projective_inverse_warp_coords_top.sv
// Throughput: one coordinate per cycle; the 12-stage pipelined divider takes a new
// quotient pair every cycle, and queue credits only throttle when pop is held off.
// Reset (rst_ni low, asynchronous): registers return to the identity mapping,
// both queues empty, and the pipelines drop all items in flight.
`default_nettype none

`include "projective_inverse_warp_coords_top_defines.svh"

module projective_inverse_warp_coords_top import piw_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned SRC_WIDTH  = SrcWidthDef,
  parameter int unsigned SRC_HEIGHT = SrcHeightDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoefW-1:0]   cfg_wdata_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [CoordW-1:0]  out_x_i,
  input  wire logic [CoordW-1:0]  out_y_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    in_range_o,
  output logic [CoordW-1:0]       src_x_o,
  output logic [CoordW-1:0]       src_y_o
);

  logic      mid_push, mid_pop, mid_full, mid_empty;
  piw_item_t mid_in, mid_head;

  piw_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .out_x_i     (out_x_i),
    .out_y_i     (out_y_i),
    .mid_pop_i   (mid_pop),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_in)
  );

  piw_fifo #(
    .WIDTH ($bits(piw_item_t)),
    .DEPTH (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_in),
    .pop_i   (mid_pop),
    .rdata_o (mid_head),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  piw_back #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_head),
    .mid_pop_o   (mid_pop),
    .pop         (pop),
    .empty       (empty),
    .in_range_o  (in_range_o),
    .src_x_o     (src_x_o),
    .src_y_o     (src_y_o)
  );

  // Front credits must keep the middle queue from overflowing
  `PIW_ASSERT_NEVER(a_mid_overflow, mid_push && mid_full && !mid_pop, "middle queue overflow")
  `PIW_ASSERT_NEVER(a_mid_underflow, mid_pop && mid_empty, "middle queue underflow")
  `PIW_ASSERT_IMPLY(a_oob_zero, !empty && !in_range_o, (src_x_o == '0) && (src_y_o == '0), "out of range result carries nonzero coordinates")

endmodule

`default_nettype wire
